// File: rtl/key_debounce_press_classifier_defines.svh
// assertion macros shared by the key debounce classifier
`ifndef KEY_DEBOUNCE_PRESS_CLASSIFIER_DEFINES_SVH
`define KEY_DEBOUNCE_PRESS_CLASSIFIER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define KDPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define KDPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/kdpc_pkg.sv
// types and constants for the key debounce classifier
package kdpc_pkg;

  localparam int unsigned TICK_PERIOD_MS = 20;
  localparam int unsigned MAX_STEPS      = 50;
  // x / 20 == (x * 52429) >> 20 for any 16-bit x
  localparam logic [15:0] RECIP_20       = 16'd52429;
  localparam int unsigned RECIP_SHIFT    = 20;

  localparam logic [5:0]  STEPS_RESET    = 6'd2;
  localparam logic [5:0]  STEPS_MIN      = 6'd1;
  localparam logic [5:0]  STEPS_MAX      = 6'(MAX_STEPS);
  localparam logic [31:0] LONG_RESET     = 32'd1000;
  localparam logic [31:0] VLONG_RESET    = 32'd3000;
  localparam logic [3:0]  KEYS_RESET     = 4'd2;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_TAKE = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_PRESS = 3'd1,
    EV_SHORT = 3'd2,
    EV_LONG  = 3'd3,
    EV_VLONG = 3'd4
  } event_code_t;

  typedef enum logic [3:0] {
    REG_DEBOUNCE = 4'd0,
    REG_LONG     = 4'd1,
    REG_VLONG    = 4'd2,
    REG_KEYS     = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        action;
    logic [7:0]  raw_levels;
    logic [31:0] now_ms;
    logic [2:0]  key_select;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic [7:0] down_mask;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  index;
    logic [31:0] data;
  } cfg_req_t;

  // broadcast to every lane
  typedef struct packed {
    logic        tick;
    logic        take;
    logic [2:0]  key_select;
    logic [7:0]  raw_levels;
    logic [31:0] now_ms;
    logic [5:0]  steps;
    logic [31:0] long_ms;
    logic [31:0] very_long_ms;
    logic [3:0]  keys_in_use;
  } lane_cmd_t;

  typedef struct packed {
    logic        stable_next;
    event_code_t code;
  } lane_stat_t;

endpackage

// File: rtl/kdpc_if.sv
// valid/ready channels of the key debounce classifier
interface kdpc_item_if import kdpc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kdpc_result_if import kdpc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kdpc_cfg_if import kdpc_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/key_debounce_press_classifier.sv
// Key debounce and press classifier, top level. One lane per key updates its
// debounce count, stable level and latched event combinationally, so a tick
// or take request is accepted every cycle while the output buffer has room
// and its result is registered. A two-entry output buffer keeps intake open
// while one result waits; intake stops only when both entries are held or in
// reset. The debounce step count is derived from debounce_ms on the configuration
// write through a reciprocal multiply. There is no clearing pass after reset.
`include "key_debounce_press_classifier_defines.svh"

module key_debounce_press_classifier import kdpc_pkg::*; #(
  parameter int unsigned NUM_KEYS = 8
) (
  input logic          clk,
  input logic          rst,
  kdpc_item_if.sink    item,
  kdpc_result_if.source result,
  kdpc_cfg_if.sink     cfg
);

  // configuration
  logic [5:0]  steps;
  logic [31:0] long_ms;
  logic [31:0] very_long_ms;
  logic [3:0]  keys_in_use;
  logic [31:0] recip_prod;
  logic [11:0] quot;
  logic [5:0]  steps_new;
  logic        cfg_fire;

  assign cfg.ready  = !rst;
  assign cfg_fire   = cfg.valid && cfg.ready;
  assign recip_prod = cfg.data.data[15:0] * RECIP_20;
  assign quot       = recip_prod[31:RECIP_SHIFT];

  always_comb begin
    if (quot == '0) begin
      steps_new = STEPS_MIN;
    end else if (quot > 12'(MAX_STEPS)) begin
      steps_new = STEPS_MAX;
    end else begin
      steps_new = quot[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps        <= STEPS_RESET;
      long_ms      <= LONG_RESET;
      very_long_ms <= VLONG_RESET;
      keys_in_use  <= KEYS_RESET;
    end else if (cfg_fire) begin
      unique case (cfg.data.index)
        REG_DEBOUNCE: steps        <= steps_new;
        REG_LONG:     long_ms      <= cfg.data.data;
        REG_VLONG:    very_long_ms <= cfg.data.data;
        REG_KEYS:     keys_in_use  <= cfg.data.data[3:0];
        default: ;
      endcase
    end
  end

  // lanes
  logic       item_fire;
  lane_cmd_t  cmd;
  lane_stat_t stat [NUM_KEYS];
  out_item_t  merged;

  assign item_fire = item.valid && item.ready;

  always_comb begin
    cmd.tick         = item_fire && item.data.action == ACT_TICK;
    cmd.take         = item_fire && item.data.action == ACT_TAKE;
    cmd.key_select   = item.data.key_select;
    cmd.raw_levels   = item.data.raw_levels;
    cmd.now_ms       = item.data.now_ms;
    cmd.steps        = steps;
    cmd.long_ms      = long_ms;
    cmd.very_long_ms = very_long_ms;
    cmd.keys_in_use  = keys_in_use;
  end

  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_lane
    kdpc_lane #(.LANE(g)) u_lane (
      .clk  (clk),
      .rst  (rst),
      .cmd  (cmd),
      .stat (stat[g])
    );
  end

  kdpc_merge #(.NUM_KEYS(NUM_KEYS)) u_merge (
    .stat   (stat),
    .item   (item.data),
    .result (merged)
  );

  // two-entry output buffer
  logic      out_valid;
  out_item_t out_q;
  logic      skid_valid;
  out_item_t skid_q;
  logic      pop;

  assign pop         = out_valid && result.ready;
  assign item.ready  = !skid_valid && !rst;
  assign result.valid = out_valid;
  assign result.data  = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= item_fire;
      end
    end else if (item_fire) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_q <= skid_valid ? skid_q : merged;
    end else if (item_fire && !out_valid) begin
      out_q <= merged;
    end
    if (item_fire && out_valid && !pop) begin
      skid_q <= merged;
    end
  end

  `KDPC_ASSERT_NOW(a_skid_behind_head, clk, rst, skid_valid, out_valid,
                   "skid entry without head entry")
  `KDPC_ASSERT_NOW(a_steps_range, clk, rst, 1'b1,
                   steps >= STEPS_MIN && steps <= STEPS_MAX, "step count out of range")
  `KDPC_ASSERT_NEXT(a_tick_no_event, clk, rst,
                    item_fire && !out_valid && item.data.action == ACT_TICK,
                    out_valid && out_q.event_code == EV_NONE, "tick result carries an event")
  `KDPC_ASSERT_NEXT(a_drain_empty, clk, rst, pop && !skid_valid && !item_fire, !out_valid,
                    "buffer not empty after last result taken")

endmodule

// File: rtl/kdpc_lane.sv
// one key: debounce counter, stable level and latched press event
module kdpc_lane import kdpc_pkg::*; #(
  parameter int unsigned LANE = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  lane_cmd_t  cmd,
  output lane_stat_t stat
);

  logic        prev_raw, prev_raw_next;
  logic        stable, stable_next;
  logic [5:0]  count, count_next;
  logic [31:0] press_time, press_time_next;
  event_code_t code, code_next;

  logic        active;
  logic        raw;
  logic [5:0]  count_inc;
  logic [31:0] held;
  event_code_t release_code;

  assign active = cmd.tick && (4'(LANE) < cmd.keys_in_use);
  assign raw    = cmd.raw_levels[LANE];
  assign held   = cmd.now_ms - press_time;

  always_comb begin
    if (held >= cmd.very_long_ms) begin
      release_code = EV_VLONG;
    end else if (held >= cmd.long_ms) begin
      release_code = EV_LONG;
    end else begin
      release_code = EV_SHORT;
    end
  end

  always_comb begin
    prev_raw_next   = prev_raw;
    stable_next     = stable;
    count_next      = count;
    press_time_next = press_time;
    code_next       = code;
    count_inc       = (count < cmd.steps) ? count + 6'd1 : count;
    if (active) begin
      if (raw != prev_raw) begin
        prev_raw_next = raw;
        count_next    = '0;
      end else begin
        count_next = count_inc;
        if (count_inc >= cmd.steps && stable != raw) begin
          stable_next = raw;
          if (raw) begin
            press_time_next = cmd.now_ms;
            code_next       = EV_PRESS;
          end else begin
            code_next = release_code;
          end
        end
      end
    end else if (cmd.take && cmd.key_select == 3'(LANE)) begin
      code_next = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_raw <= 1'b0;
      stable   <= 1'b0;
      count    <= '0;
      code     <= EV_NONE;
    end else begin
      prev_raw <= prev_raw_next;
      stable   <= stable_next;
      count    <= count_next;
      code     <= code_next;
    end
  end

  always_ff @(posedge clk) begin
    press_time <= press_time_next;
  end

  // take returns the code held before this request clears it
  assign stat.stable_next = stable_next;
  assign stat.code        = code;

endmodule

// File: rtl/kdpc_merge.sv
// gathers the lanes into one result: selected event and down mask
module kdpc_merge import kdpc_pkg::*; #(
  parameter int unsigned NUM_KEYS = 8
) (
  input  lane_stat_t stat [NUM_KEYS],
  input  in_item_t   item,
  output out_item_t  result
);

  always_comb begin
    result.event_code = EV_NONE;
    result.down_mask  = '0;
    for (int unsigned i = 0; i < NUM_KEYS; i++) begin
      result.down_mask[i] = stat[i].stable_next;
      if (item.action == ACT_TAKE && item.key_select == 3'(i)) begin
        result.event_code = stat[i].code;
      end
    end
  end

endmodule

// File: bench/key_debounce_press_classifier_test.sv
// self-checking bench for the key debounce classifier: directed drill, then random press bursts
module key_debounce_press_classifier_test;
  import kdpc_pkg::*;

  localparam int NUM_KEYS    = 8;
  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_WAIT  = 4;
  localparam int DRILL_LEN   = 27;

  typedef struct {
    in_item_t  req;
    logic      typed;
    out_item_t answer;
  } drill_row_t;

  logic clk;
  logic rst;

  kdpc_item_if   item_ch ();
  kdpc_result_if res_ch ();
  kdpc_cfg_if    cfg_ch ();

  key_debounce_press_classifier #(.NUM_KEYS(NUM_KEYS)) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // register copies
  logic [15:0] cfg_debounce;
  logic [31:0] cfg_long;
  logic [31:0] cfg_vlong;
  logic [3:0]  cfg_keys;

  // per-key copies of the debounce and event state
  logic [7:0]  raw_last;
  logic [7:0]  down_now;
  logic [5:0]  settle_cnt [NUM_KEYS];
  logic [31:0] pressed_at [NUM_KEYS];
  logic [7:0]  ev_latched;
  event_code_t ev_code [NUM_KEYS];

  out_item_t   report_q [$];
  out_item_t   predicted;
  out_item_t   oldest;
  out_item_t   typed_answer = '0;
  logic        answer_typed = 1'b0;
  int          error_count = 0;
  int          sent_count = 0;
  int          send_idle_pct = 8;
  int          recv_idle_pct = 84;
  int          cycle_count;
  logic [31:0] clock_ms = '0;

  // default registers: two steps, keys 0 and 1, long 1000, very long 3000
  drill_row_t drill_rows [DRILL_LEN] = '{
    '{'{ACT_TAKE, 8'h00, 32'h0000_0000, 3'd0}, 1'b1, '{EV_NONE, 8'h00}},
    '{'{ACT_TAKE, 8'hFF, 32'hFFFF_FFFF, 3'd7}, 1'b1, '{EV_NONE, 8'h00}},
    '{'{ACT_TICK, 8'hFF, 32'h0000_0000, 3'd7}, 1'b1, '{EV_NONE, 8'h00}},
    '{'{ACT_TICK, 8'hFF, 32'd100,       3'd7}, 1'b0, '{EV_NONE, 8'h00}},
    '{'{ACT_TICK, 8'hFF, 32'd200,       3'd7}, 1'b0, '{EV_NONE, 8'h00}},
    '{'{ACT_TAKE, 8'h00, 32'h0000_0000, 3'd0}, 1'b0, '{EV_NONE, 8'h00}},
    '{'{ACT_TAKE, 8'h00, 32'h0000_0000, 3'd0}, 1'b0, '{EV_NONE, 8'h00}},
    '{'{ACT_TICK, 8'h00, 32'hFFFF_FF00, 3'd7}, 1'b0, '{EV_NONE, 8'h00}},
    '{'{ACT_TICK, 8'h00, 32'hFFFF_FFF0, 3'd7}, 1'b0, '{EV_NONE, 8'h00}},
    '{'{ACT_TICK, 8'h00, 32'h0000_0100, 3'd7}, 1'b0, '{EV_NONE, 8'h00}},
    '{'{ACT_TAKE, 8'h00, 32'h0000_0000, 3'd1}, 1'b0, '{EV_NONE, 8'h00}},
    '{'{ACT_TAKE, 8'h00, 32'h0000_0000, 3'd0}, 1'b0, '{EV_NONE, 8'h00}},
    '{'{ACT_TICK, 8'h01, 32'hFFFF_FC00, 3'd7}, 1'b0, '{EV_NONE, 8'h00}},
    '{'{ACT_TICK, 8'h01, 32'hFFFF_FC10, 3'd7}, 1'b0, '{EV_NONE, 8'h00}},
    '{'{ACT_TICK, 8'h01, 32'hFFFF_FC20, 3'd7}, 1'b0, '{EV_NONE, 8'h00}},
    '{'{ACT_TICK, 8'h00, 32'h0000_0500, 3'd7}, 1'b0, '{EV_NONE, 8'h00}},
    '{'{ACT_TICK, 8'h00, 32'h0000_0510, 3'd7}, 1'b0, '{EV_NONE, 8'h00}},
    '{'{ACT_TICK, 8'h00, 32'h0000_0520, 3'd7}, 1'b0, '{EV_NONE, 8'h00}},
    '{'{ACT_TAKE, 8'h00, 32'h0000_0000, 3'd0}, 1'b0, '{EV_NONE, 8'h00}},
    '{'{ACT_TICK, 8'h02, 32'd10,        3'd7}, 1'b0, '{EV_NONE, 8'h00}},
    '{'{ACT_TICK, 8'h02, 32'd10,        3'd7}, 1'b0, '{EV_NONE, 8'h00}},
    '{'{ACT_TICK, 8'h02, 32'd10,        3'd7}, 1'b0, '{EV_NONE, 8'h00}},
    '{'{ACT_TICK, 8'h00, 32'd9,         3'd7}, 1'b0, '{EV_NONE, 8'h00}},
    '{'{ACT_TICK, 8'h00, 32'd9,         3'd7}, 1'b0, '{EV_NONE, 8'h00}},
    '{'{ACT_TICK, 8'h00, 32'd9,         3'd7}, 1'b0, '{EV_NONE, 8'h00}},
    '{'{ACT_TAKE, 8'h00, 32'h0000_0000, 3'd1}, 1'b0, '{EV_NONE, 8'h00}},
    '{'{ACT_TICK, 8'hFF, 32'hFFFF_FFFF, 3'd0}, 1'b0, '{EV_NONE, 8'h00}}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [5:0] settle_steps();
    logic [15:0] q;
    q = cfg_debounce / 16'(TICK_PERIOD_MS);
    if (q < 16'(STEPS_MIN)) return STEPS_MIN;
    if (q > 16'(STEPS_MAX)) return STEPS_MAX;
    return q[5:0];
  endfunction

  function automatic out_item_t debounce_and_classify(in_item_t req);
    logic [5:0]  steps;
    logic [31:0] held;
    logic        raw;
    int          active;
    out_item_t   report;
    steps  = settle_steps();
    active = (cfg_keys > NUM_KEYS) ? NUM_KEYS : int'(cfg_keys);
    report.event_code = EV_NONE;
    if (req.action == ACT_TICK) begin
      for (int k = 0; k < active; k++) begin
        raw = req.raw_levels[k];
        if (raw != raw_last[k]) begin
          // a level change restarts the count
          raw_last[k]   = raw;
          settle_cnt[k] = '0;
        end else begin
          if (settle_cnt[k] < steps) settle_cnt[k] = settle_cnt[k] + 6'd1;
          if (settle_cnt[k] >= steps && down_now[k] != raw) begin
            down_now[k]   = raw;
            ev_latched[k] = 1'b1;
            if (raw) begin
              pressed_at[k] = req.now_ms;
              ev_code[k]    = EV_PRESS;
            end else begin
              // held time wraps with the millisecond counter
              held = req.now_ms - pressed_at[k];
              if (held >= cfg_vlong) ev_code[k] = EV_VLONG;
              else if (held >= cfg_long) ev_code[k] = EV_LONG;
              else ev_code[k] = EV_SHORT;
            end
          end
        end
      end
    end else if (ev_latched[req.key_select]) begin
      report.event_code = ev_code[req.key_select];
      ev_latched[req.key_select] = 1'b0;
      ev_code[req.key_select]    = EV_NONE;
    end
    report.down_mask = down_now;
    return report;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg_debounce = 16'd40;
      cfg_long     = LONG_RESET;
      cfg_vlong    = VLONG_RESET;
      cfg_keys     = KEYS_RESET;
      raw_last     = '0;
      down_now     = '0;
      ev_latched   = '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        settle_cnt[k] = '0;
        pressed_at[k] = '0;
        ev_code[k]    = EV_NONE;
      end
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.data.index)
          REG_DEBOUNCE: cfg_debounce = cfg_ch.data.data[15:0];
          REG_LONG:     cfg_long     = cfg_ch.data.data;
          REG_VLONG:    cfg_vlong    = cfg_ch.data.data;
          REG_KEYS:     cfg_keys     = cfg_ch.data.data[3:0];
          default: ;
        endcase
      end
      if (item_ch.valid && item_ch.ready) begin
        predicted = debounce_and_classify(item_ch.data);
        report_q.push_back(answer_typed ? typed_answer : predicted);
      end
      if (res_ch.valid && res_ch.ready) begin
        if (report_q.size() == 0) begin
          $display("%0t: result with nothing awaited, event_code %0d down_mask %02h",
                   $time, res_ch.data.event_code, res_ch.data.down_mask);
          error_count++;
        end else begin
          oldest = report_q.pop_front();
          if (res_ch.data.event_code != oldest.event_code) begin
            $display("%0t: event_code expected %0d got %0d",
                     $time, oldest.event_code, res_ch.data.event_code);
            error_count++;
          end
          if (res_ch.data.down_mask != oldest.down_mask) begin
            $display("%0t: down_mask expected %02h got %02h",
                     $time, oldest.down_mask, res_ch.data.down_mask);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // entered at a falling edge; returns at the falling edge after acceptance with valid still high
  task automatic send_request(in_item_t req, logic typed, out_item_t answer);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    answer_typed  = typed;
    typed_answer  = answer;
    item_ch.valid <= 1'b1;
    item_ch.data  <= req;
    do @(posedge clk); while (!item_ch.ready);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic tick_keys(logic [7:0] raw, logic [31:0] now);
    in_item_t req;
    req = '{ACT_TICK, raw, now, 3'($urandom)};
    send_request(req, 1'b0, '0);
  endtask

  task automatic take_event(logic [2:0] sel);
    in_item_t req;
    req = '{ACT_TAKE, 8'($urandom), 32'($urandom), sel};
    send_request(req, 1'b0, '0);
  endtask

  task automatic drain_reports();
    item_ch.valid <= 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_register(logic [3:0] index, logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index, value};
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // unused upper data bits are filled at random, and one write goes to an unmapped index
  task automatic apply_settings(logic [15:0] deb, logic [31:0] lng, logic [31:0] vlng,
                                logic [3:0] keys);
    drain_reports();
    write_register(REG_DEBOUNCE, {16'($urandom), deb});
    write_register(REG_LONG, lng);
    write_register(REG_VLONG, vlng);
    write_register(REG_KEYS, {28'($urandom), keys});
    write_register(4'($urandom_range(4, 15)), $urandom);
  endtask

  task automatic random_burst();
    logic [7:0] pattern;
    int         hold;
    int         kind;
    kind = $urandom_range(0, 99);
    if (kind < 75) begin
      // hold one pattern long enough to settle, then collect some events
      pattern  = 8'($urandom);
      clock_ms = clock_ms + (($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2500));
      hold     = settle_steps() + 1 + $urandom_range(0, 2);
      repeat (hold) begin
        clock_ms = clock_ms + $urandom_range(15, 25);
        tick_keys(pattern, clock_ms);
      end
      repeat ($urandom_range(0, 3)) take_event(3'($urandom));
    end else begin
      // bouncing levels and stray take requests
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 1) == 0) begin
          clock_ms = clock_ms + $urandom_range(0, 100);
          tick_keys(8'($urandom), clock_ms);
        end else begin
          take_event(3'($urandom));
        end
      end
    end
    if ($urandom_range(0, 99) < 4) drain_reports();
  endtask

  task automatic run_random(int chunk);
    int goal;
    goal = sent_count + chunk;
    while (sent_count < goal) random_burst();
  endtask

  initial begin
    rst           = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.data  = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (drill_rows[n]) send_request(drill_rows[n].req, drill_rows[n].typed,
                                         drill_rows[n].answer);

    apply_settings(16'd0, 32'd0, 32'hFFFF_FFFF, 4'd8);
    run_random(90);
    apply_settings(16'hFFFF, 32'd500, 32'd2000, 4'd15);
    run_random(110);

    send_idle_pct = 84;
    recv_idle_pct = 8;
    // very long threshold below the long one, and no key processed
    apply_settings(16'd19, 32'd3000, 32'd1000, 4'd0);
    run_random(40);
    apply_settings(16'd100, 32'd200, 32'd600, 4'd3);
    run_random(100);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings(16'd1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd1);
    run_random(100);
    apply_settings(16'($urandom_range(0, 300)), $urandom_range(0, 3000),
                   $urandom_range(0, 6000), 4'($urandom_range(0, 15)));
    run_random(110);

    drain_reports();
    if (error_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
